### hdl/pcb_pkg.sv
package pcb_pkg;

    // Buffer geometry (DEPTH must be a power of two)
    localparam int DEPTH       = 1024;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int SAMPLE_BITS = 16;

    // Register field widths
    localparam int LEN_W  = 11;
    localparam int OFF_W  = 12;
    localparam int ACQ_W  = 16;
    localparam int CNT_W  = 12;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_RECORD_LENGTH     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TRIGGER_OFFSET    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ACQUISITION_COUNT = 2'd2;

    // Register reset values
    localparam logic [LEN_W-1:0] RST_RECORD_LENGTH     = 11'd256;
    localparam logic [OFF_W-1:0] RST_TRIGGER_OFFSET    = 12'd0;
    localparam logic [ACQ_W-1:0] RST_ACQUISITION_COUNT = 16'd1000;

    // Request type codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [SAMPLE_BITS-1:0] sample_value;
        logic                   comparator_high;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_out;
        logic                   record_last;
        logic                   run_last;
    } t_out_item;

    // Ring memory access from the controller
    typedef struct packed {
        logic                   we;
        logic [PTR_W-1:0]       waddr;
        logic [SAMPLE_BITS-1:0] wdata;
        logic                   re;
        logic [PTR_W-1:0]       raddr;
    } t_ram_req;

    // Read issued this cycle, with the marks for its result
    typedef struct packed {
        logic valid;
        logic record_last;
        logic run_last;
    } t_rd_issue;

endpackage

### hdl/pcb_ring.sv
module pcb_ring (
    input  logic                            i_clk,
    input  pcb_pkg::t_ram_req               i_req,
    output logic [pcb_pkg::SAMPLE_BITS-1:0] o_rd_data
);
    import pcb_pkg::*;

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/pcb_out.sv
module pcb_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pcb_pkg::t_rd_issue              i_issue,
    input  logic [pcb_pkg::SAMPLE_BITS-1:0] i_rd_data,
    output logic                            o_slot_free,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pcb_pkg::t_out_item              o_out
);
    import pcb_pkg::*;

    logic      r_pend;
    logic      r_pend_rec;
    logic      r_pend_run;
    logic      r_ov;
    t_out_item r_out;
    logic      w_move;

    // Pending read moves on when the output register is empty or draining
    assign w_move      = r_pend && (!r_ov || i_out_ready);
    assign o_slot_free = !r_pend || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_issue.valid) begin
                r_pend <= 1'b1;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end
            if (w_move) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (i_issue.valid) begin
            r_pend_rec <= i_issue.record_last;
            r_pend_run <= i_issue.run_last;
        end
        if (w_move) begin
            r_out.sample_out  <= i_rd_data;
            r_out.record_last <= r_pend_rec;
            r_out.run_last    <= r_pend_run;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

### hdl/pcb_ctrl.sv
module pcb_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pcb_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [pcb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  pcb_pkg::t_in_item            i_in,
    input  logic                         i_slot_free,
    output pcb_pkg::t_ram_req            o_ram,
    output pcb_pkg::t_rd_issue           o_issue
);
    import pcb_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_LOW,
        PH_WAIT_HIGH,
        PH_POST,
        PH_READ
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ACQ_W-1:0] r_done, n_done;
    logic             r_clearing;
    logic [PTR_W-1:0] r_clr_addr;

    logic [LEN_W-1:0] r_record_length;
    logic [OFF_W-1:0] r_trigger_offset;
    logic [ACQ_W-1:0] r_acq_count;

    logic             w_accept;
    logic             w_tick;
    logic [CNT_W-1:0] w_eff_len;
    logic signed [CNT_W+1:0] w_post_sum;
    logic [CNT_W-1:0] w_post;
    logic [PTR_W-1:0] w_wp_inc;
    logic [PTR_W-1:0] w_rp_start;
    logic [CNT_W-1:0] w_cnt_dec;
    logic [ACQ_W-1:0] w_done_inc;
    logic             w_store;
    logic             w_read;
    logic             w_rec_last;
    logic             w_run_last;

    assign o_in_ready = !r_clearing && ((r_phase != PH_READ) || i_slot_free);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_tick     = w_accept && (i_in.req_type == REQ_TICK);

    // Effective record length: zero reads as one, clamp at buffer depth
    always_comb begin
        w_eff_len = CNT_W'(r_record_length);
        if (r_record_length == '0) begin
            w_eff_len = CNT_W'(1);
        end else if (32'(r_record_length) > 32'(DEPTH)) begin
            w_eff_len = CNT_W'(DEPTH);
        end
    end

    // Post-trigger count, clamped at zero
    assign w_post_sum = $signed({2'b00, w_eff_len})
                      + $signed({{2{r_trigger_offset[OFF_W-1]}}, r_trigger_offset});
    assign w_post     = w_post_sum[CNT_W+1] ? '0 : w_post_sum[CNT_W-1:0];

    assign w_wp_inc   = r_wp + 1'b1;
    assign w_rp_start = PTR_W'(32'(w_wp_inc) - 32'(w_eff_len));
    assign w_cnt_dec  = r_cnt - 1'b1;
    assign w_done_inc = r_done + 1'b1;
    assign w_rec_last = (w_cnt_dec == '0);
    assign w_run_last = w_rec_last && (w_done_inc >= r_acq_count);

    // Next state of the acquisition sequencer
    always_comb begin
        n_phase = r_phase;
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_cnt   = r_cnt;
        n_done  = r_done;
        w_store = 1'b0;
        w_read  = 1'b0;
        if (w_accept && (i_in.req_type == REQ_START)) begin
            if ((r_phase == PH_IDLE) && (r_acq_count != '0)) begin
                n_done  = '0;
                n_cnt   = '0;
                n_phase = PH_WAIT_LOW;
            end
        end else if (w_tick) begin
            unique case (r_phase)
                PH_WAIT_LOW: begin
                    w_store = 1'b1;
                    n_wp    = w_wp_inc;
                    if (!i_in.comparator_high) begin
                        n_phase = PH_WAIT_HIGH;
                    end
                end
                PH_WAIT_HIGH: begin
                    w_store = 1'b1;
                    n_wp    = w_wp_inc;
                    if (i_in.comparator_high) begin
                        if (w_post == '0) begin
                            n_rp    = w_rp_start;
                            n_cnt   = w_eff_len;
                            n_phase = PH_READ;
                        end else begin
                            n_cnt   = w_post;
                            n_phase = PH_POST;
                        end
                    end
                end
                PH_POST: begin
                    w_store = 1'b1;
                    n_wp    = w_wp_inc;
                    n_cnt   = w_cnt_dec;
                    if (w_cnt_dec == '0) begin
                        n_rp    = w_rp_start;
                        n_cnt   = w_eff_len;
                        n_phase = PH_READ;
                    end
                end
                PH_READ: begin
                    w_read = 1'b1;
                    n_rp   = r_rp + 1'b1;
                    n_cnt  = w_cnt_dec;
                    if (w_rec_last) begin
                        n_done  = w_done_inc;
                        n_phase = w_run_last ? PH_IDLE : PH_WAIT_LOW;
                    end
                end
                default: begin
                    w_store = 1'b1;
                    n_wp    = w_wp_inc;
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Ring access: clearing pass after reset, then capture writes and readout
    always_comb begin
        o_ram.we    = r_clearing || w_store;
        o_ram.waddr = r_clearing ? r_clr_addr : r_wp;
        o_ram.wdata = r_clearing ? '0 : i_in.sample_value;
        o_ram.re    = w_read;
        o_ram.raddr = r_rp;
    end

    assign o_issue.valid       = w_read;
    assign o_issue.record_last = w_rec_last;
    assign o_issue.run_last    = w_run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_wp             <= '0;
            r_rp             <= '0;
            r_cnt            <= '0;
            r_done           <= '0;
            r_clearing       <= 1'b1;
            r_clr_addr       <= '0;
            r_record_length  <= RST_RECORD_LENGTH;
            r_trigger_offset <= RST_TRIGGER_OFFSET;
            r_acq_count      <= RST_ACQUISITION_COUNT;
        end else begin
            r_phase <= n_phase;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == PTR_W'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            // Register writes, unknown index ignored
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RECORD_LENGTH:     r_record_length  <= i_cfg_data[LEN_W-1:0];
                    CFG_TRIGGER_OFFSET:    r_trigger_offset <= i_cfg_data[OFF_W-1:0];
                    CFG_ACQUISITION_COUNT: r_acq_count      <= i_cfg_data[ACQ_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### hdl/pretrigger_capture_buffer.sv
// Pretrigger capture buffer: one request accepted per cycle while o_in_ready is high.
// A readout sample is held in the ring's registered read port, then in the output register.
// Throughput: one request per cycle; a readout request waits only while the
// output register and the pending read slot are both full and the output is not taken.
// Reset (synchronous, active low) starts a clearing pass over all DEPTH entries
// of the ring that zeroes them; no request is accepted until it ends.
module pretrigger_capture_buffer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pcb_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [pcb_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  pcb_pkg::t_in_item          i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output pcb_pkg::t_out_item         o_out
);
    import pcb_pkg::*;

    t_ram_req               w_ram;
    t_rd_issue              w_issue;
    logic [SAMPLE_BITS-1:0] w_rd_data;
    logic                   w_slot_free;

    // Sequencer, pointers and registers
    pcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_slot_free (w_slot_free),
        .o_ram       (w_ram),
        .o_issue     (w_issue)
    );

    // Sample ring
    pcb_ring u_ring (
        .i_clk     (i_clk),
        .i_req     (w_ram),
        .o_rd_data (w_rd_data)
    );

    // Result staging
    pcb_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (w_issue),
        .i_rd_data   (w_rd_data),
        .o_slot_free (w_slot_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pcb_pkg::*;

    localparam int RANDOM_REQUESTS = 200;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 10;

    // Index that maps to no register
    localparam logic [CIDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT_LOW,
        ST_WAIT_HIGH,
        ST_POST,
        ST_READ
    } t_acq_state;

    // Acquisition predictor plus the queue of readout samples still owed
    class readout_scoreboard;
        t_out_item               expected_readout[$];
        int                      errors;
        logic [SAMPLE_BITS-1:0]  ring [DEPTH];
        logic [PTR_W-1:0]        wr_ptr;
        logic [PTR_W-1:0]        rd_ptr;
        t_acq_state              state;
        logic [CNT_W-1:0]        phase_cnt;
        logic [ACQ_W-1:0]        records_done;
        logic [LEN_W-1:0]        rec_len;
        logic signed [OFF_W-1:0] trig_off;
        logic [ACQ_W-1:0]        acq_count;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_ptr       = '0;
            rd_ptr       = '0;
            state        = ST_IDLE;
            phase_cnt    = '0;
            records_done = '0;
            rec_len      = RST_RECORD_LENGTH;
            trig_off     = RST_TRIGGER_OFFSET;
            acq_count    = RST_ACQUISITION_COUNT;
            errors       = 0;
        endfunction

        function void write_register(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_RECORD_LENGTH:     rec_len   = data[LEN_W-1:0];
                CFG_TRIGGER_OFFSET:    trig_off  = data[OFF_W-1:0];
                CFG_ACQUISITION_COUNT: acq_count = data[ACQ_W-1:0];
                default: ;
            endcase
        endfunction

        // zero reads as one, anything past the ring as the whole ring
        function int readout_length();
            int len;
            len = rec_len;
            if (len == 0) len = 1;
            if (len > DEPTH) len = DEPTH;
            return len;
        endfunction

        function void store(logic [SAMPLE_BITS-1:0] v);
            ring[wr_ptr] = v;
            wr_ptr = wr_ptr + 1'b1;
        endfunction

        // readout ends on the last stored sample
        function void start_readout();
            int len;
            len       = readout_length();
            rd_ptr    = wr_ptr - PTR_W'(len);
            phase_cnt = CNT_W'(len);
            state     = ST_READ;
        endfunction

        function void note_request(t_in_item it);
            t_out_item res;
            int        post;
            if (it.req_type == REQ_START) begin
                if (state == ST_IDLE && acq_count != 0) begin
                    records_done = '0;
                    phase_cnt    = '0;
                    state        = ST_WAIT_LOW;
                end
                return;
            end
            case (state)
                ST_WAIT_LOW: begin
                    store(it.sample_value);
                    if (!it.comparator_high) state = ST_WAIT_HIGH;
                end
                ST_WAIT_HIGH: begin
                    store(it.sample_value);
                    if (it.comparator_high) begin
                        post = readout_length() + $signed(trig_off);
                        if (post <= 0) begin
                            start_readout();
                        end else begin
                            phase_cnt = CNT_W'(post);
                            state     = ST_POST;
                        end
                    end
                end
                ST_POST: begin
                    store(it.sample_value);
                    phase_cnt = phase_cnt - 1'b1;
                    if (phase_cnt == 0) start_readout();
                end
                ST_READ: begin
                    // capture halted: the tick only pulls the next sample out
                    res.sample_out  = ring[rd_ptr];
                    rd_ptr          = rd_ptr + 1'b1;
                    phase_cnt       = phase_cnt - 1'b1;
                    res.record_last = (phase_cnt == 0);
                    res.run_last    = 1'b0;
                    if (res.record_last) begin
                        records_done = records_done + 1'b1;
                        if (records_done >= acq_count) begin
                            res.run_last = 1'b1;
                            state        = ST_IDLE;
                        end else begin
                            state = ST_WAIT_LOW;
                        end
                    end
                    expected_readout.push_back(res);
                end
                default: store(it.sample_value);
            endcase
        endfunction

        function void check_readout(t_out_item got);
            t_out_item exp;
            if (expected_readout.size() == 0) begin
                errors++;
                $display("%0t: unexpected readout: sample %h record_last %b run_last %b",
                         $time, got.sample_out, got.record_last, got.run_last);
                return;
            end
            exp = expected_readout.pop_front();
            if (got.sample_out !== exp.sample_out) begin
                errors++;
                $display("%0t: sample_out expected %h got %h",
                         $time, exp.sample_out, got.sample_out);
            end
            if (got.record_last !== exp.record_last) begin
                errors++;
                $display("%0t: record_last expected %b got %b",
                         $time, exp.record_last, got.record_last);
            end
            if (got.run_last !== exp.run_last) begin
                errors++;
                $display("%0t: run_last expected %b got %b",
                         $time, exp.run_last, got.run_last);
            end
        endfunction

        function int pending();
            return expected_readout.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out;

    readout_scoreboard   sb = new();
    int                  gap_max = 0;
    int                  stall_max = 0;
    bit                  out_hold_req = 1'b0;
    int                  items_sent = 0;
    int                  idle_cycles = 0;

    pretrigger_capture_buffer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Request side: optional gap, then hold the request until taken
    task automatic send_req(t_in_item it);
        int gap;
        gap = $urandom_range(0, gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(it);
        items_sent++;
    endtask

    task automatic send_tick(logic [SAMPLE_BITS-1:0] s, logic c);
        t_in_item it;
        it = '{req_type: REQ_TICK, sample_value: s, comparator_high: c};
        send_req(it);
    endtask

    task automatic send_start();
        t_in_item it;
        it = '{req_type: REQ_START, sample_value: 16'($urandom), comparator_high: 1'($urandom)};
        send_req(it);
    endtask

    task automatic program_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        sb.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(int len, int off, int acq);
        program_reg(CFG_RECORD_LENGTH, CFG_W'(len));
        program_reg(CFG_TRIGGER_OFFSET, CFG_W'(off));
        program_reg(CFG_ACQUISITION_COUNT, CFG_W'(acq));
    endtask

    // Stop offering, let every owed sample come out, then allow for the pipeline
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Bias the comparator so that acquisitions make progress
    function automatic logic pick_comparator();
        case (sb.state)
            ST_WAIT_LOW:  return $urandom_range(0, 3) == 0;
            ST_WAIT_HIGH: return $urandom_range(0, 2) == 0;
            default:      return 1'($urandom);
        endcase
    endfunction

    task automatic finish_run(int max_ticks, bit hold_at_readout);
        int n;
        n = 0;
        while (sb.state != ST_IDLE && n < max_ticks) begin
            if (hold_at_readout && sb.state == ST_READ) begin
                out_hold_req    = 1'b1;
                hold_at_readout = 1'b0;
            end
            send_tick(random_sample(), pick_comparator());
            n++;
        end
    endtask

    task automatic random_phase();
        int len;
        int off;
        int acq;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) len = 0;
        else if (r < 3) len = $urandom_range(17, 64);
        else len = $urandom_range(1, 16);
        r = $urandom_range(0, 9);
        if (r == 0) off = -1024;
        else if (r == 1) off = -((len == 0) ? 1 : len);
        else off = $urandom_range(0, 20) - 10;
        r = $urandom_range(0, 15);
        if (r == 0) acq = 0;
        else if (r == 1) acq = 65535;
        else acq = $urandom_range(1, 4);
        drain();
        set_config(len, off, acq);
        gap_max   = $urandom_range(0, 1) ? 10 : 0;
        stall_max = $urandom_range(0, 1) ? 10 : 0;
        repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                send_start();
                finish_run(150, 1'b0);
            end else if (r == 7) begin
                // noise: loose ticks and starts
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 3) == 0) send_start();
                    else send_tick(random_sample(), 1'($urandom));
                end
            end else begin
                // run broken off part way
                send_start();
                repeat ($urandom_range(1, 12)) send_tick(random_sample(), 1'($urandom));
            end
        end
    endtask

    // Result side: per-sample stall, plus one long hold-off on request
    initial begin
        int w;
        forever begin
            @(negedge i_clk);
            if (out_hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_hold_req = 1'b0;
            end
            w = $urandom_range(0, stall_max);
            if (w > 0) begin
                i_out_ready = 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_readout(o_out);
        end
    end

    // Watchdog: consecutive cycles with no request moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n;
        int random_base;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Short records, post count below length, readout wrapping past the
        // top of the ring into cleared entries, two records per run
        set_config(16, -14, 2);
        send_tick(16'hFFFF, 1'b1);
        send_tick(16'h0000, 1'b0);
        send_start();
        send_start();
        send_tick(16'hA5A5, 1'b1);
        send_tick(16'h5A5A, 1'b0);
        send_tick(16'h8001, 1'b1);
        finish_run(200, 1'b0);

        // Negative sum: readout on the tick after the trigger. Count lowered mid-run.
        drain();
        set_config(2, -1024, 5);
        send_start();
        n = 0;
        while (sb.records_done < 2 && n < 400) begin
            send_tick(random_sample(), pick_comparator());
            n++;
        end
        drain();
        program_reg(CFG_ACQUISITION_COUNT, CFG_W'(1));
        finish_run(400, 1'b0);

        // Zero count: start ignored
        drain();
        set_config(3, 0, 0);
        send_start();
        send_tick(16'h7FFF, 1'b0);
        send_tick(16'h8000, 1'b1);

        // Length zero used as one
        drain();
        set_config(0, 0, 1);
        send_start();
        finish_run(200, 1'b0);

        // Long post-trigger stretch; hold the output off during readout
        drain();
        gap_max   = 10;
        stall_max = 10;
        set_config(32, 0, 1);
        send_start();
        finish_run(400, 1'b1);

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_REQUESTS) random_phase();

        // Oversized length clamped, unknown register ignored, largest record
        // count: run still going when stimulus stops
        drain();
        gap_max   = 0;
        stall_max = 0;
        set_config(2047, -1020, 65535);
        program_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        send_start();
        repeat (60) send_tick(random_sample(), pick_comparator());

        drain();
        repeat (END_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
